// ----- rtl/core/periodic_timer_bank_unit_defines.svh -----
// Assertion helpers for the periodic timer bank.
`ifndef PERIODIC_TIMER_BANK_UNIT_DEFINES_SVH
`define PERIODIC_TIMER_BANK_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PTB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ptb check failed");

// Next-cycle implication, checked out of reset.
`define PTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ptb check failed");

`endif

// ----- rtl/core/ptb_pkg.sv -----
package ptb_pkg;

    localparam int TIMER_COUNT_DEF = 8;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int ID_W            = 4;
    localparam int PERIOD_W        = 32;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_STOP   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_EXPIRY = 2'd3;

    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    // timer store operations
    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_STEP  = 3'd4;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [ID_W-1:0]     timer_id;
        logic [PERIOD_W-1:0] period;
    } t_in_item;

    typedef struct packed {
        logic [1:0]      kind;
        logic            status;
        logic [ID_W-1:0] which_timer;
        logic            last;
    } t_result;

    typedef struct packed {
        logic [2:0]          op;
        logic [ID_W-1:0]     idx;
        logic [PERIOD_W-1:0] period;
    } t_store_ctl;

    typedef struct packed {
        logic expired;  // step brought it to zero
    } t_store_stat;

    typedef struct packed {
        logic    strobe;
        t_result res;
    } t_emit;

endpackage

// ----- rtl/core/ptb_store.sv -----
module ptb_store #(
    parameter int TIMER_COUNT = ptb_pkg::TIMER_COUNT_DEF,
    parameter int COUNT_WIDTH = ptb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptb_pkg::t_store_ctl  i_ctl,
    output ptb_pkg::t_store_stat o_stat
);

    localparam int IdxW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

    logic [TIMER_COUNT-1:0] r_enabled;
    logic [COUNT_WIDTH-1:0] r_count  [TIMER_COUNT];
    logic [COUNT_WIDTH-1:0] r_reload [TIMER_COUNT];

    logic [IdxW-1:0]        idx;
    logic [COUNT_WIDTH-1:0] dec;
    logic                   hit_zero;

    assign idx = i_ctl.idx[IdxW-1:0];

    // the one shared decrement and zero compare
    assign dec      = r_count[idx] - COUNT_WIDTH'(1);
    assign hit_zero = (dec == '0);

    assign o_stat.expired = (i_ctl.op == ptb_pkg::OP_STEP) && r_enabled[idx] && hit_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= '0;
        end else begin
            unique case (i_ctl.op)
                ptb_pkg::OP_LOAD:  r_enabled[idx] <= 1'b1;
                ptb_pkg::OP_STOP:  r_enabled[idx] <= 1'b0;
                ptb_pkg::OP_CLEAR: r_enabled      <= '0;
                default: ;
            endcase
        end
    end

    // count/reload only matter while enabled; a start rewrites both
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            ptb_pkg::OP_LOAD: begin
                r_count[idx]  <= i_ctl.period[COUNT_WIDTH-1:0];
                r_reload[idx] <= i_ctl.period[COUNT_WIDTH-1:0];
            end
            ptb_pkg::OP_STEP: begin
                if (r_enabled[idx]) begin
                    r_count[idx] <= hit_zero ? r_reload[idx] : dec;
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/core/ptb_seq.sv -----
`include "periodic_timer_bank_unit_defines.svh"

module ptb_seq #(
    parameter int TIMER_COUNT = ptb_pkg::TIMER_COUNT_DEF,
    parameter int COUNT_WIDTH = ptb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  ptb_pkg::t_in_item    i_item,
    output logic                 o_busy,
    output ptb_pkg::t_store_ctl  o_ctl,
    input  ptb_pkg::t_store_stat i_stat,
    output ptb_pkg::t_emit       o_emit
);

    localparam int IdxW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(TIMER_COUNT - 1);
    localparam logic [ptb_pkg::ID_W:0] IdLimit = (ptb_pkg::ID_W + 1)'(TIMER_COUNT);
    localparam logic [ptb_pkg::PERIOD_W-1:0] CntMax =
        ptb_pkg::PERIOD_W'((64'd1 << COUNT_WIDTH) - 64'd1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]                r_state, n_state;
    ptb_pkg::t_in_item         r_item, n_item;
    logic [IdxW-1:0]           r_idx, n_idx;
    logic                      r_pend_vld, n_pend_vld;
    logic [ptb_pkg::ID_W-1:0]  r_pend_id, n_pend_id;

    logic id_ok;
    logic period_ok;

    assign id_ok     = ({1'b0, r_item.timer_id} < IdLimit);
    assign period_ok = (r_item.period != '0) && (r_item.period <= CntMax);
    assign o_busy    = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_idx      = r_idx;
        n_pend_vld = r_pend_vld;
        n_pend_id  = r_pend_id;

        o_ctl.op     = ptb_pkg::OP_NOP;
        o_ctl.idx    = r_item.timer_id;
        o_ctl.period = r_item.period;

        o_emit.strobe          = 1'b0;
        o_emit.res.kind        = ptb_pkg::KIND_EXPIRY;
        o_emit.res.status      = ptb_pkg::STAT_OK;
        o_emit.res.which_timer = r_pend_id;
        o_emit.res.last        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item     = i_item;
                    n_idx      = '0;
                    n_pend_vld = 1'b0;
                    n_state    = (i_item.cmd == ptb_pkg::CMD_TICK) ? S_WALK : S_EXEC;
                end
            end
            S_EXEC: begin
                o_emit.strobe          = 1'b1;
                o_emit.res.last        = 1'b1;
                o_emit.res.which_timer = r_item.timer_id;
                case (r_item.cmd)
                    ptb_pkg::CMD_START: begin
                        o_emit.res.kind = ptb_pkg::KIND_START;
                        if (id_ok && period_ok) begin
                            o_ctl.op = ptb_pkg::OP_LOAD;
                        end else begin
                            o_emit.res.status = ptb_pkg::STAT_ERR;
                        end
                    end
                    ptb_pkg::CMD_STOP: begin
                        o_emit.res.kind = ptb_pkg::KIND_STOP;
                        if (id_ok) begin
                            o_ctl.op = ptb_pkg::OP_STOP;
                        end else begin
                            o_emit.res.status = ptb_pkg::STAT_ERR;
                        end
                    end
                    default: begin
                        o_emit.res.kind        = ptb_pkg::KIND_CLEAR;
                        o_emit.res.which_timer = '0;
                        o_ctl.op               = ptb_pkg::OP_CLEAR;
                    end
                endcase
                n_state = S_IDLE;
            end
            S_WALK: begin
                o_ctl.op  = ptb_pkg::OP_STEP;
                o_ctl.idx = ptb_pkg::ID_W'(r_idx);
                // hold one expiry back so the final one can carry last
                if (i_stat.expired) begin
                    o_emit.strobe = r_pend_vld;
                    n_pend_vld    = 1'b1;
                    n_pend_id     = ptb_pkg::ID_W'(r_idx);
                end
                if (r_idx == LastIdx) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx = r_idx + IdxW'(1);
                end
            end
            default: begin
                o_emit.strobe   = r_pend_vld;
                o_emit.res.last = 1'b1;
                n_pend_vld      = 1'b0;
                n_state         = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend_vld <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            r_idx      <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_pend_id <= n_pend_id;
    end

    `PTB_ASSERT_NOW(a_no_emit_idle, i_clk, i_rst_n, r_state == S_IDLE, !o_emit.strobe)
    `PTB_ASSERT_NOW(a_exec_single, i_clk, i_rst_n, r_state == S_EXEC, o_emit.strobe && o_emit.res.last)
    `PTB_ASSERT_NOW(a_walk_not_last, i_clk, i_rst_n, r_state == S_WALK && o_emit.strobe, !o_emit.res.last && i_stat.expired)
    `PTB_ASSERT_NEXT(a_flush_done, i_clk, i_rst_n, r_state == S_FLUSH, r_state == S_IDLE && !r_pend_vld)
    `PTB_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, r_state == S_IDLE && i_start, o_busy)

endmodule

// ----- rtl/core/periodic_timer_bank_unit.sv -----
// Periodic timer bank. A word is accepted when start is high while busy is low.
// Start, stop and clear-all commands hold busy high in the execute state, and the
// acknowledge word shows in the cycle right after it; a tick keeps busy high
// while the single decrement/compare unit visits one timer per cycle in
// ascending id order, and then in a flush state that releases the held-back
// final expiry. Results come out on o_result for exactly one cycle under
// o_strobe, in the cycle after they are formed, and cannot be held off by the
// receiver; a tick with expiries gives one word per expired timer, the final
// one with last set, and a quiet tick gives none. Busy drops in the cycle the
// final result of a command is shown.
module periodic_timer_bank_unit #(
    parameter int TIMER_COUNT = ptb_pkg::TIMER_COUNT_DEF,
    parameter int COUNT_WIDTH = ptb_pkg::COUNT_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ptb_pkg::t_in_item i_item,
    output logic              o_strobe,
    output ptb_pkg::t_result  o_result
);

    ptb_pkg::t_store_ctl  store_ctl;
    ptb_pkg::t_store_stat store_stat;
    ptb_pkg::t_emit       emit;

    logic             r_strobe;
    ptb_pkg::t_result r_result;

    // sequencer: command decode, timer walk, held-back expiry for last flag
    ptb_seq #(
        .TIMER_COUNT (TIMER_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .o_busy  (busy),
        .o_ctl   (store_ctl),
        .i_stat  (store_stat),
        .o_emit  (emit)
    );

    // timer state plus the shared decrementer
    ptb_store #(
        .TIMER_COUNT (TIMER_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (store_ctl),
        .o_stat  (store_stat)
    );

    // output register: each result word shows for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= emit.strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.strobe) begin
            r_result <= emit.res;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
